// ----- sv/sorted_sleep_timer_queue_macros.svh -----
// Assertion macros for the sorted sleep timer queue.
`ifndef SORTED_SLEEP_TIMER_QUEUE_MACROS_SVH
`define SORTED_SLEEP_TIMER_QUEUE_MACROS_SVH

// Check that a condition implies another at every clock edge out of reset.
`define SSTQ_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sstq check failed");

// Check that a condition holds at every clock edge out of reset.
`define SSTQ_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("sstq check failed");

`endif

// ----- sv/sstq_pkg.sv -----
// Types and constants shared by the sorted sleep timer queue.
package sstq_pkg;

    localparam int TIME_W      = 32;
    localparam int ID_W        = 8;
    localparam int ENTRY_W     = TIME_W + ID_W;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_SLEEP = 1'b1;

    typedef enum logic [1:0] {
        KIND_ACCEPT = 2'd0,
        KIND_WOKEN  = 2'd1,
        KIND_NONE   = 2'd2,
        KIND_FULL   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] time_now;
        logic              empty;
        logic              last;
    } t_result;

endpackage

// ----- sv/sstq_mem.sv -----
// Entry memory: one write port, one read port, registered read data.
module sstq_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic [sstq_pkg::ENTRY_W-1:0] i_wdata,
    input  logic                         i_re,
    input  logic [AW-1:0]                i_raddr,
    output logic [sstq_pkg::ENTRY_W-1:0] o_rdata
);
    import sstq_pkg::*;

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/sstq_seq.sv -----
// Sequencer: time counter, ring pointers, insert and expire walks, result register.
module sstq_seq #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_op,
    input  logic [sstq_pkg::ID_W-1:0]    i_id,
    input  logic [sstq_pkg::TIME_W-1:0]  i_dur,
    output logic                         o_valid,
    input  logic                         i_ready,
    output sstq_pkg::t_result            o_res,
    output logic [CW-1:0]                o_count,
    output logic                         o_mem_we,
    output logic [AW-1:0]                o_mem_waddr,
    output logic [sstq_pkg::ENTRY_W-1:0] o_mem_wdata,
    output logic                         o_mem_re,
    output logic [AW-1:0]                o_mem_raddr,
    input  logic [sstq_pkg::ENTRY_W-1:0] i_mem_rdata
);
    import sstq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TCHK,
        ST_SCHK,
        ST_PUT0,
        ST_DONE
    } t_state;

    localparam logic [AW:0]   DEPTH_A = (AW+1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    t_state            r_state, n_state;
    logic [TIME_W-1:0] r_now, n_now;
    logic [TIME_W-1:0] r_wake, n_wake;
    logic [ID_W-1:0]   r_id, n_id;
    logic [AW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_idx, n_idx;
    logic              r_pend, n_pend;
    logic [ID_W-1:0]   r_pend_id, n_pend_id;
    logic              r_pend_empty, n_pend_empty;
    t_result           r_res, n_res;
    t_result           r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic              out_free;
    logic [TIME_W-1:0] rd_wake;
    logic [ID_W-1:0]   rd_id;
    logic              has;
    logic              stop;

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [AW-1:0] lg);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, lg};
        if (sum >= DEPTH_A) begin
            sum = sum - DEPTH_A;
        end
        return sum[AW-1:0];
    endfunction

    assign rd_wake  = i_mem_rdata[TIME_W-1:0];
    assign rd_id    = i_mem_rdata[ENTRY_W-1:TIME_W];
    assign out_free = !r_out_valid || i_ready;
    assign has      = (r_count != '0) && (rd_wake <= r_now);
    assign stop     = (r_idx != '0) ? (rd_wake < r_wake) : (rd_wake <= r_wake);

    always_comb begin
        n_state      = r_state;
        n_now        = r_now;
        n_wake       = r_wake;
        n_id         = r_id;
        n_head       = r_head;
        n_count      = r_count;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_pend_id    = r_pend_id;
        n_pend_empty = r_pend_empty;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_ready;
        o_mem_we     = 1'b0;
        o_mem_waddr  = r_head;
        o_mem_wdata  = {r_id, r_wake};
        o_mem_re     = 1'b0;
        o_mem_raddr  = r_head;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_op == OP_TICK) begin
                        n_now    = r_now + 1'b1;
                        n_pend   = 1'b0;
                        o_mem_re = 1'b1;
                        n_state  = ST_TCHK;
                    end else begin
                        n_wake = r_now + i_dur;
                        n_id   = i_id;
                        if (r_count == DEPTH_C) begin
                            n_res   = '{KIND_FULL, i_id, r_now, r_count == '0, 1'b1};
                            n_state = ST_DONE;
                        end else if (r_count == '0) begin
                            o_mem_we    = 1'b1;
                            o_mem_wdata = {i_id, n_wake};
                            n_count     = CW'(1);
                            n_res       = '{KIND_ACCEPT, i_id, r_now, 1'b0, 1'b1};
                            n_state     = ST_DONE;
                        end else begin
                            n_idx       = AW'(r_count - 1'b1);
                            o_mem_re    = 1'b1;
                            o_mem_raddr = f_phys(r_head, n_idx);
                            n_state     = ST_SCHK;
                        end
                    end
                end
            end
            ST_TCHK: begin
                if (out_free) begin
                    if (has) begin
                        if (r_pend) begin
                            n_out       = '{KIND_WOKEN, r_pend_id, r_now, r_pend_empty, 1'b0};
                            n_out_valid = 1'b1;
                        end
                        n_pend       = 1'b1;
                        n_pend_id    = rd_id;
                        n_pend_empty = (r_count == CW'(1));
                        n_head       = f_phys(r_head, AW'(1));
                        n_count      = r_count - 1'b1;
                        o_mem_re     = 1'b1;
                        o_mem_raddr  = n_head;
                    end else begin
                        if (r_pend) begin
                            n_out = '{KIND_WOKEN, r_pend_id, r_now, r_pend_empty, 1'b1};
                        end else begin
                            n_out = '{KIND_NONE, '0, r_now, r_count == '0, 1'b1};
                        end
                        n_out_valid = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end
            end
            ST_SCHK: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = f_phys(r_head, r_idx + 1'b1);
                if (stop) begin
                    n_count = r_count + 1'b1;
                    n_res   = '{KIND_ACCEPT, r_id, r_now, 1'b0, 1'b1};
                    n_state = ST_DONE;
                end else begin
                    o_mem_wdata = i_mem_rdata;
                    if (r_idx == '0) begin
                        n_state = ST_PUT0;
                    end else begin
                        n_idx       = r_idx - 1'b1;
                        o_mem_re    = 1'b1;
                        o_mem_raddr = f_phys(r_head, n_idx);
                    end
                end
            end
            ST_PUT0: begin
                o_mem_we = 1'b1;
                n_count  = r_count + 1'b1;
                n_res    = '{KIND_ACCEPT, r_id, r_now, 1'b0, 1'b1};
                n_state  = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_now       <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_now       <= n_now;
            r_head      <= n_head;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_wake       <= n_wake;
        r_id         <= n_id;
        r_idx        <= n_idx;
        r_pend_id    <= n_pend_id;
        r_pend_empty <= n_pend_empty;
        r_res        <= n_res;
        r_out        <= n_out;
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign o_count = r_count;

endmodule

// ----- sv/sorted_sleep_timer_queue.sv -----
// Top level of the sorted sleep timer queue.
// Input words on s_*: s_tuser is the operation (0 tick, 1 sleep); s_tdata holds
// thread_id and duration. Result words on m_*: m_tuser is the kind, m_tlast marks
// the final result of an input word, m_tdata holds woken_id, time_now, queue_empty.
// One input word is taken at a time; s_tready is high while the sequencer is idle.
// A tick reads the head entry from the ring memory, then reads one more entry
// per woken thread; results leave the output register one per cycle as long as
// m_tready does not stall them. A sleep walks the list from the tail, one memory
// read and one shift write per cycle; a reject or an insert into an empty list
// needs no walk.
// Reset (synchronous, active low) clears the time, the fill count and the ring
// pointer; the memory itself is not cleared, as only filled entries are read.
// While m_tready is low a valid result word holds, and the sequencer waits before it writes another result.
module sorted_sleep_timer_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // thread_id[7:0], duration[39:8]
    input  logic        s_tuser,  // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [sstq_pkg::OUT_TDATA_W-1:0] m_tdata,  // woken_id[7:0], time_now[39:8],
                                                       // queue_empty[40], zero
    output logic [1:0]  m_tuser,  // kind
    output logic        m_tlast
);
    import sstq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;
    t_result            res;
    logic [CW-1:0]      count;

    sstq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    sstq_seq #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_tvalid),
        .o_ready     (s_tready),
        .i_op        (s_tuser),
        .i_id        (s_tdata[ID_W-1:0]),
        .i_dur       (s_tdata[IN_TDATA_W-1:ID_W]),
        .o_valid     (m_tvalid),
        .i_ready     (m_tready),
        .o_res       (res),
        .o_count     (count),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    assign m_tdata = {7'b0, res.empty, res.time_now, res.id};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

    `include "sorted_sleep_timer_queue_macros.svh"

    `SSTQ_ASSERT_ALWAYS(a_count_bound, count <= CW'(QUEUE_DEPTH))
    `SSTQ_ASSERT_IMPLY(a_single_last, m_tvalid && (res.kind != KIND_WOKEN), m_tlast)
    `SSTQ_ASSERT_IMPLY(a_accept_nonempty, m_tvalid && (res.kind == KIND_ACCEPT), !res.empty)

endmodule

// ----- tb/sv/tb_sorted_sleep_timer_queue.sv -----
// Testbench for the sorted sleep timer queue: directed and random sleeps and ticks.
module tb_sorted_sleep_timer_queue;
    import sstq_pkg::*;

    localparam int DEPTH = 16;
    localparam int LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    sorted_sleep_timer_queue #(.QUEUE_DEPTH(DEPTH)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always #5 i_clk = ~i_clk;

    logic [31:0] clock_now;
    logic [31:0] wake_list[$];
    logic [7:0]  thread_list[$];
    t_result     pending_results[$];
    int          errors = 0;
    int          words_sent = 0;
    int          results_seen = 0;
    int          cycles = 0;
    int          hold_off = 0;
    bit          idle_en = 1'b1;

    task automatic predict_word(input logic op, input logic [7:0] id, input logic [31:0] dur);
        t_result r;
        logic [31:0] wake;
        int pos;
        int n;
        if (op == OP_SLEEP) begin
            r.id = id;
            r.last = 1'b1;
            if (wake_list.size() >= DEPTH) begin
                r.kind = KIND_FULL;
                r.empty = 1'b0;
            end else begin
                wake = clock_now + dur;
                if (wake_list.size() == 0 || wake_list[0] > wake) begin
                    pos = 0;
                end else begin
                    pos = 1;
                    while (pos < wake_list.size() && wake_list[pos] < wake) pos++;
                end
                wake_list.insert(pos, wake);
                thread_list.insert(pos, id);
                r.kind = KIND_ACCEPT;
                r.empty = 1'b0;
            end
            r.time_now = clock_now;
            pending_results.push_back(r);
        end else begin
            clock_now = clock_now + 1;
            n = 0;
            while (n < wake_list.size() && wake_list[n] <= clock_now) n++;
            if (n == 0) begin
                r.kind = KIND_NONE;
                r.id = '0;
                r.time_now = clock_now;
                r.empty = (wake_list.size() == 0);
                r.last = 1'b1;
                pending_results.push_back(r);
            end else begin
                for (int i = 0; i < n; i++) begin
                    r.kind = KIND_WOKEN;
                    r.id = thread_list[0];
                    r.time_now = clock_now;
                    void'(wake_list.pop_front());
                    void'(thread_list.pop_front());
                    r.empty = (wake_list.size() == 0);
                    r.last = (i == n - 1);
                    pending_results.push_back(r);
                end
            end
        end
    endtask

    task automatic send_word(input logic op, input logic [7:0] id, input logic [31:0] dur);
        while (idle_en && $urandom_range(99) < 31) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {dur, id};
        predict_word(op, id, dur);
        do @(posedge i_clk); while (!s_tready);
        words_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(idle_en && $urandom_range(99) < 31);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, actual %h %h %b", $time, m_tuser, m_tdata,
                    m_tlast);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (m_tuser !== e.kind || m_tdata[7:0] !== e.id
                        || m_tdata[39:8] !== e.time_now || m_tdata[40] !== e.empty
                        || m_tdata[47:41] !== 7'd0 || m_tlast !== e.last) begin
                    $display("%0t: mismatch, expected kind %0d id %0d time %0d empty %b last %b,",
                        $time, e.kind, e.id, e.time_now, e.empty, e.last);
                    $display("%0t:   actual kind %0d id %0d time %0d empty %b last %b",
                        $time, m_tuser, m_tdata[7:0], m_tdata[39:8], m_tdata[40], m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic test_extremes();
        send_word(OP_TICK, 8'hFF, 32'hFFFF_FFFF);
        send_word(OP_SLEEP, 8'h00, 32'h0);
        send_word(OP_SLEEP, 8'hFF, 32'hFFFF_FFFF);
        send_word(OP_SLEEP, 8'h5A, 32'h0);
        send_word(OP_SLEEP, 8'hA5, 32'h3);
        send_word(OP_SLEEP, 8'h11, 32'h3);
        send_word(OP_TICK, 8'h00, 32'h0);
        send_word(OP_TICK, 8'h00, 32'h0);
        send_word(OP_TICK, 8'h00, 32'h0);
        send_word(OP_TICK, 8'h00, 32'h0);
        drain_results();
    endtask

    task automatic test_full_and_burst();
        for (int i = 0; i < DEPTH + 2; i++) send_word(OP_SLEEP, 8'(i + 1), 32'(2 + (i % 3)));
        send_word(OP_TICK, 8'h00, 32'h0);
        send_word(OP_TICK, 8'h00, 32'h0);
        send_word(OP_TICK, 8'h00, 32'h0);
        send_word(OP_TICK, 8'h00, 32'h0);
        drain_results();
    endtask

    task automatic test_wrap();
        send_word(OP_SLEEP, 8'h77, 32'hFFFF_FFF0);
        send_word(OP_SLEEP, 8'h78, 32'hFFFF_FFF0);
        send_word(OP_TICK, 8'h00, 32'h0);
        drain_results();
    endtask

    task automatic test_stall_backpressure();
        hold_off = 400;
        for (int i = 0; i < 12; i++) send_word(OP_SLEEP, 8'($urandom), $urandom_range(20));
        for (int i = 0; i < 8; i++) send_word(OP_TICK, 8'($urandom), $urandom);
        drain_results();
    endtask

    task automatic test_random(input int count);
        logic [31:0] d;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) idle_en = 1'b0;
            if (i == count / 2 + 40) idle_en = 1'b1;
            case ($urandom_range(9))
                0: d = $urandom;
                1: d = 32'hFFFF_FFFF - $urandom_range(30);
                default: d = $urandom_range(12);
            endcase
            if ($urandom_range(99) < 50) send_word(OP_SLEEP, 8'($urandom), d);
            else send_word(OP_TICK, 8'($urandom), $urandom);
        end
        drain_results();
    endtask

    initial begin
        clock_now = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_full_and_burst();
        test_wrap();
        test_stall_backpressure();
        test_random(215);
        $display("Sent %0d words and checked %0d results: extremes, full list, wrap,",
            words_sent, results_seen);
        $display("long receiver stall and random sleep/tick traffic.");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
